@@ design/utx_pkg.sv @@
// Package for the UART transmitter with byte FIFO.
// Holds the shared constants, the action codes and the queue item type.
// No dependencies.
package utx_pkg;

    localparam int FIFO_DEPTH  = 16;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int FRAME_BITS  = 10;
    localparam int BITS_W      = $clog2(FRAME_BITS + 1);
    localparam int DATA_W      = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_PUSH = 1'b1;

    typedef struct packed {
        logic              action;
        logic [DATA_W-1:0] data_byte;
    } item_t;

endpackage

@@ design/uart_tx_with_fifo.sv @@
// Channel   Handshake            Payload
// s_        s_valid / s_ready    s_action, s_data_byte
// m_        m_valid / m_ready    m_line_level, m_push_accepted, m_fifo_full
// cfg_      cfg_valid/cfg_ready  cfg_invert_line
//
// One beat per clock is sustained while m_ready stays high; a beat's result passes
// first through the front queue and then the back end's output register.
// The back end handles each tick or push combinationally against its FIFO state.
// Reset is synchronous and active low and leaves the line at mark with an empty FIFO.
// A stall on m_ready fills the two-entry front queue, after which s_ready drops.
// cfg_ready is always high; the invert setting reaches the line at the next tick.
//
// Top level of the UART transmitter; depends on utx_pkg, utx_front and utx_back.
module uart_tx_with_fifo (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_action,
    input  logic [utx_pkg::DATA_W-1:0] s_data_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_line_level,
    output logic                       m_push_accepted,
    output logic                       m_fifo_full,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_invert_line
);
    import utx_pkg::*;

    item_t q_item;
    logic  q_valid, q_ready;

    assign cfg_ready = 1'b1;

    utx_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_data_byte (s_data_byte),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    utx_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_invert      (cfg_invert_line),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_line_level    (m_line_level),
        .m_push_accepted (m_push_accepted),
        .m_fifo_full     (m_fifo_full)
    );

endmodule

@@ design/utx_front.sv @@
// Front end of the UART transmitter: accepts input beats, tags them as
// tick or push and holds them in a short queue for the back end.
// Depends on utx_pkg.
module utx_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_action,
    input  logic [utx_pkg::DATA_W-1:0] s_data_byte,
    output logic                       q_valid,
    input  logic                       q_ready,
    output utx_pkg::item_t             q_item
);
    import utx_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;
    item_t             in_item;

    function automatic logic [QPTR_W-1:0] qadv(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        in_item.action    = (s_action == ACT_PUSH) ? ACT_PUSH : ACT_TICK;
        in_item.data_byte = s_data_byte;
        wr_ptr_next = push ? qadv(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? qadv(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ design/utx_back.sv @@
// Back end of the UART transmitter: byte FIFO, frame shifter, line register
// and the registered result beat. Also holds the invert setting.
// Depends on utx_pkg.
module utx_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  utx_pkg::item_t q_item,
    input  logic           cfg_we,
    input  logic           cfg_invert,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_line_level,
    output logic           m_push_accepted,
    output logic           m_fifo_full
);
    import utx_pkg::*;

    logic [DATA_W-1:0]     mem [FIFO_DEPTH];
    logic [PTR_W-1:0]      rp_reg, rp_next;
    logic [PTR_W-1:0]      wp_reg, wp_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [BITS_W-1:0]     bits_reg, bits_next;
    logic                  prep_reg, prep_next;
    logic                  line_reg, line_next;
    logic                  invert_reg;
    logic                  m_valid_reg, m_valid_next;
    logic                  level_reg, accepted_reg, full_reg;
    logic                  take, wr_en, accepted, full_now;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign q_ready  = !m_valid_reg || m_ready;
    assign take     = q_valid && q_ready;
    assign full_now = (adv(wp_reg) == rp_reg);

    always_comb begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        prep_next  = prep_reg;
        line_next  = line_reg;
        wr_en      = 1'b0;
        accepted   = 1'b0;
        if (take) begin
            case (q_item.action)
                ACT_PUSH: begin
                    if (!full_now) begin
                        wr_en    = 1'b1;
                        wp_next  = adv(wp_reg);
                        accepted = 1'b1;
                    end
                end
                ACT_TICK: begin
                    line_next = prep_reg ^ invert_reg;
                    if (bits_reg == '0) begin
                        if (rp_reg == wp_reg) begin
                            prep_next = 1'b1;
                        end else begin
                            // The start bit goes out as the prepared bit right away,
                            // so the stored word already holds stop bit and data.
                            prep_next  = 1'b0;
                            shift_next = {1'b0, 1'b1, mem[rp_reg]};
                            bits_next  = BITS_W'(FRAME_BITS - 1);
                            rp_next    = adv(rp_reg);
                        end
                    end else begin
                        prep_next  = shift_reg[0];
                        shift_next = {1'b0, shift_reg[FRAME_BITS-1:1]};
                        bits_next  = bits_reg - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg      <= '0;
            wp_reg      <= '0;
            shift_reg   <= '0;
            bits_reg    <= '0;
            prep_reg    <= 1'b1;
            line_reg    <= 1'b1;
            invert_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rp_reg      <= rp_next;
            wp_reg      <= wp_next;
            shift_reg   <= shift_next;
            bits_reg    <= bits_next;
            prep_reg    <= prep_next;
            line_reg    <= line_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                invert_reg <= cfg_invert;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            level_reg    <= line_next;
            accepted_reg <= accepted;
            full_reg     <= (adv(wp_next) == rp_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wp_reg] <= q_item.data_byte;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_line_level    = level_reg;
    assign m_push_accepted = accepted_reg;
    assign m_fifo_full     = full_reg;

endmodule

@@ design/utx_checker.sv @@
// Port-level checker for the UART transmitter, bound to the top level.
// Depends on utx_pkg and uart_tx_with_fifo.
module utx_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_action,
    input logic [utx_pkg::DATA_W-1:0] s_data_byte,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_line_level,
    input logic                       m_push_accepted,
    input logic                       m_fifo_full,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic                       cfg_invert_line
);
    import utx_pkg::*;

    // A result beat held back by the sink keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_line_level)
            && $stable(m_push_accepted) && $stable(m_fifo_full))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending.
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Right after reset the queue is empty and takes a beat.
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    // A beat accepted while no result is pending is followed by a result.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> ##1 m_valid)
        else $error("accepted beat produced no result");

    // The configuration port never stalls.
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind uart_tx_with_fifo utx_checker u_utx_checker (.*);

@@ tb/tb.sv @@
// Self-checking testbench for uart_tx_with_fifo: a bit-level predictor of the
// FIFO, the frame shifter and the line register checks every result beat.
// Depends on utx_pkg and the uart_tx_with_fifo RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utx_pkg::*;

    localparam int IDLE_PCT    = 28;
    localparam int PHASE_ITEMS = 457;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic line_level;
        logic push_accepted;
        logic fifo_full;
    } tx_result_t;

    // Tracks the transmitter state and holds the results it predicts, oldest first.
    class tx_line_board;
        logic [DATA_W-1:0] bytes_held [FIFO_DEPTH];
        int                rd_ptr;
        int                wr_ptr;
        logic [9:0]        frame_bits;
        int                bits_left;
        logic              staged_bit;
        logic              line_now;
        logic              invert;
        tx_result_t        predicted [$];
        int                errors;

        function new();
            rd_ptr     = 0;
            wr_ptr     = 0;
            frame_bits = '0;
            bits_left  = 0;
            staged_bit = 1'b1;
            line_now   = 1'b1;
            invert     = 1'b0;
            errors     = 0;
        endfunction

        function int pending();
            return predicted.size();
        endfunction

        function logic is_full();
            return ((wr_ptr + 1) % FIFO_DEPTH) == rd_ptr;
        endfunction

        function void set_invert(logic v);
            invert = v;
        endfunction

        task report(string msg);
            errors++;
            $display("%0t ns: mismatch: %s", $time, msg);
        endtask

        // Advances the prediction by one accepted input beat.
        function void take_beat(logic act, logic [DATA_W-1:0] data);
            tx_result_t r;
            r.push_accepted = 1'b0;
            if (act == ACT_PUSH) begin
                if (!is_full()) begin
                    bytes_held[wr_ptr] = data;
                    wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
                    r.push_accepted = 1'b1;
                end
            end else begin
                // The line takes the bit prepared on the previous tick.
                line_now = staged_bit ^ invert;
                if (bits_left == 0 && rd_ptr == wr_ptr) begin
                    staged_bit = 1'b1;
                end else begin
                    if (bits_left == 0) begin
                        frame_bits = {1'b1, bytes_held[rd_ptr], 1'b0};
                        bits_left  = FRAME_BITS;
                        rd_ptr     = (rd_ptr + 1) % FIFO_DEPTH;
                    end
                    staged_bit = frame_bits[0];
                    frame_bits = frame_bits >> 1;
                    bits_left--;
                end
            end
            r.line_level = line_now;
            r.fifo_full  = is_full();
            predicted.push_back(r);
        endfunction

        task match_output(tx_result_t got);
            tx_result_t want;
            if (predicted.size() == 0) begin
                report("result beat with no prediction waiting");
                return;
            end
            want = predicted.pop_front();
            if (got.line_level !== want.line_level)
                report($sformatf("line_level got %b want %b", got.line_level, want.line_level));
            if (got.push_accepted !== want.push_accepted)
                report($sformatf("push_accepted got %b want %b",
                                 got.push_accepted, want.push_accepted));
            if (got.fifo_full !== want.fifo_full)
                report($sformatf("fifo_full got %b want %b", got.fifo_full, want.fifo_full));
        endtask
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_action = ACT_TICK;
    logic [DATA_W-1:0] s_data_byte = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_line_level;
    logic              m_push_accepted;
    logic              m_fifo_full;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_invert_line = 1'b0;
    logic              calm = 1'b0;
    int                stall_cycles = 0;
    tx_line_board      board = new();

    uart_tx_with_fifo dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_line_level    (m_line_level),
        .m_push_accepted (m_push_accepted),
        .m_fifo_full     (m_fifo_full),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_invert_line (cfg_invert_line)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Beat monitor and stall watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                board.set_invert(cfg_invert_line);
            if (s_valid && s_ready)
                board.take_beat(s_action, s_data_byte);
            if (m_valid && m_ready)
                board.match_output({m_line_level, m_push_accepted, m_fifo_full});
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_item(input logic act, input logic [DATA_W-1:0] data);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_data_byte <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Writes the invert setting once every predicted result has come back.
    task automatic write_invert(input logic v);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_valid       <= 1'b1;
        cfg_invert_line <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int                push_pct;
        logic              act;
        logic [DATA_W-1:0] data;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: byte extremes, filling the FIFO to full, pushes into a
        // full FIFO, then ticks that start the first frame.
        write_invert(1'b0);
        send_item(ACT_PUSH, 8'h00);
        send_item(ACT_PUSH, 8'hFF);
        send_item(ACT_PUSH, 8'h01);
        send_item(ACT_PUSH, 8'h80);
        for (int i = 0; i < 12; i++)
            send_item(ACT_PUSH, (i % 2) ? 8'hAA : 8'h55);
        send_item(ACT_PUSH, 8'h3C);
        for (int i = 0; i < 8; i++)
            send_item(ACT_TICK, 8'hFF);

        // Random phases alternate the invert setting. Bursts lean toward pushes
        // or ticks or mix them evenly, so the FIFO both fills up and drains.
        push_pct = 50;
        for (int ph = 0; ph < 4; ph++) begin
            write_invert(ph % 2 == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 40 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       push_pct = 8;
                        1:       push_pct = 50;
                        default: push_pct = 92;
                    endcase
                end
                calm = (ph == 1 && k >= 100 && k < 350);
                act  = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_TICK;
                case ($urandom_range(0, 9))
                    0:       data = 8'h00;
                    1:       data = 8'hFF;
                    default: data = DATA_W'($urandom_range(0, 255));
                endcase
                send_item(act, data);
            end
        end

        s_valid <= 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
        if (board.errors == 0 && board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
